// ===== sv/id_allocator_free_list_core_assert.svh =====
// assertion macros for the id allocator
// used by the controller and the top level
`ifndef ID_ALLOCATOR_FREE_LIST_CORE_ASSERT_SVH
`define ID_ALLOCATOR_FREE_LIST_CORE_ASSERT_SVH

// a condition that must hold in every cycle
`define IDA_ASSERT_IMP(label, c, a, e) \
  label: assert property (@(posedge c) disable iff (e) (a)) else $error("check failed");

// a condition that implies another in the next cycle
`define IDA_ASSERT_NEXT(label, c, x, y, e) \
  label: assert property (@(posedge c) disable iff (e) (x) |=> (y)) else $error("check failed");

`endif

// ===== sv/ida_pkg.sv =====
// shared types and constants for the id allocator
// no dependencies
package ida_pkg;

  localparam int MAX_IDS = 1024;
  localparam int IW = $clog2(MAX_IDS);
  localparam logic [IW-1:0] ID_TOP = IW'(MAX_IDS - 1);

  localparam logic [2:0] CMD_TAKE    = 3'd0;
  localparam logic [2:0] CMD_FREE    = 3'd1;
  localparam logic [2:0] CMD_RESERVE = 3'd2;
  localparam logic [2:0] CMD_CHECK   = 3'd3;
  localparam logic [2:0] CMD_NEXT    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EXH   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_SAME  = 2'd3;

  // memory selectors
  localparam logic [1:0] MEM_FWD  = 2'd0;
  localparam logic [1:0] MEM_BWD  = 2'd1;
  localparam logic [1:0] MEM_FREE = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [9:0]  id_in;
  } req_t;

  typedef struct packed {
    logic [9:0] id_out;
    logic [1:0] status;
    logic       id_is_free;
    logic [9:0] taken_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [1:0]    wr_sel;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] wr_data;
  } mem_cmd_t;

  // datapath to controller: registered read data of all three arrays
  typedef struct packed {
    logic [IW-1:0] fwd;
    logic [IW-1:0] bwd;
    logic          free;
  } mem_rsp_t;

endpackage

// ===== sv/ida_datapath.sv =====
// link and flag memories of the id allocator
// depends on ida_pkg
module ida_datapath (
  input  logic              clk,
  input  ida_pkg::mem_cmd_t cmd,
  output ida_pkg::mem_rsp_t rsp
);

  logic [ida_pkg::IW-1:0] fwd_mem  [ida_pkg::MAX_IDS];
  logic [ida_pkg::IW-1:0] bwd_mem  [ida_pkg::MAX_IDS];
  logic                   free_mem [ida_pkg::MAX_IDS];

  // one write port, one registered read port per array
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      case (cmd.wr_sel)
        ida_pkg::MEM_FWD:  fwd_mem[cmd.wr_addr] <= cmd.wr_data;
        ida_pkg::MEM_BWD:  bwd_mem[cmd.wr_addr] <= cmd.wr_data;
        ida_pkg::MEM_FREE: free_mem[cmd.wr_addr] <= cmd.wr_data[0];
        default: ;
      endcase
    end
    if (cmd.rd_en) begin
      rsp.fwd  <= fwd_mem[cmd.rd_addr];
      rsp.bwd  <= bwd_mem[cmd.rd_addr];
      rsp.free <= free_mem[cmd.rd_addr];
    end
  end

endmodule

// ===== sv/ida_ctrl.sv =====
// sequencer of the id allocator: list registers and command steps
// depends on ida_pkg and the assertion header
`include "id_allocator_free_list_core_assert.svh"
module ida_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ida_pkg::req_t     req,
  input  logic              max_id_wr,
  input  logic [9:0]        max_id_data,
  output ida_pkg::mem_cmd_t mcmd,
  input  ida_pkg::mem_rsp_t mrsp,
  output logic              done,
  output ida_pkg::rsp_t     result
);

  localparam int IW = ida_pkg::IW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;  // read entry id, wait
  localparam logic [3:0] S_EVAL  = 4'd2;  // read data valid
  localparam logic [3:0] S_UNL1  = 4'd3;  // fwd[p] <= n
  localparam logic [3:0] S_UNL2  = 4'd4;  // bwd[n] <= p
  localparam logic [3:0] S_APP1  = 4'd5;  // free flag of id
  localparam logic [3:0] S_APP2  = 4'd6;  // bwd[id]
  localparam logic [3:0] S_APP3  = 4'd7;  // fwd[tail], or bwd[head] on a free push
  localparam logic [3:0] S_APP4  = 4'd8;  // fwd[id]
  localparam logic [3:0] S_FILL1 = 4'd9;  // free flag of i
  localparam logic [3:0] S_FILL2 = 4'd10; // bwd[i]
  localparam logic [3:0] S_FILL3 = 4'd11; // fwd[i]
  localparam logic [3:0] S_FLNK  = 4'd12; // fwd[free_tail] <= first
  localparam logic [3:0] S_RD2   = 4'd13; // reread id after fill
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0]    state, state_next;
  logic [9:0]    max_id;
  logic [IW-1:0] high_water, free_head, free_tail, taken_head, taken_tail;
  logic [IW:0]   free_total;
  logic [2:0]    cmd;
  logic [9:0]    idr;
  logic [IW-1:0] id, lp, ln, fi, first;
  logic          to_free;  // append target: 1 free push, 0 taken append
  logic [9:0]    r_id_out;
  logic [1:0]    r_status;
  logic          r_free;
  logic [IW-1:0] lim;
  logic          taken_now, in_mem;

  assign lim = (max_id > 10'(ida_pkg::ID_TOP)) ? ida_pkg::ID_TOP : IW'(max_id);
  assign in_mem = ({1'b0, idr} < 11'(ida_pkg::MAX_IDS));
  assign taken_now = (idr != 10'd0) && in_mem && (IW'(idr) <= high_water) && !mrsp.free;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_id <= 10'd1023;
    end else begin
      state <= state_next;
      if (max_id_wr) max_id <= max_id_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_RD;
      S_RD:   state_next = S_EVAL;
      S_EVAL: begin
        state_next = S_DONE;
        case (cmd)
          ida_pkg::CMD_TAKE: begin
            if (free_total != '0 && free_head != '0) state_next = S_UNL1;
            else if (high_water < lim) state_next = S_APP1;
          end
          ida_pkg::CMD_FREE:
            if (idr != 10'd0 && in_mem && taken_now) state_next = S_UNL1;
          ida_pkg::CMD_RESERVE:
            if (idr != 10'd0 && IW'(idr) <= lim && in_mem && !taken_now) begin
              if (IW'(idr) > high_water) state_next = S_FILL1;
              else state_next = S_UNL1;
            end
          default: ;
        endcase
      end
      S_UNL1: state_next = S_UNL2;
      S_UNL2: state_next = S_APP1;
      S_APP1: state_next = S_APP2;
      S_APP2: state_next = S_APP3;
      S_APP3: state_next = S_APP4;
      S_APP4: state_next = S_DONE;
      S_FILL1: state_next = S_FILL2;
      S_FILL2: state_next = S_FILL3;
      S_FILL3: state_next = (fi == id) ? S_FLNK : S_FILL1;
      S_FLNK: state_next = S_RD2;
      S_RD2:  state_next = S_EVAL;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory commands
  always_comb begin
    mcmd = '0;
    mcmd.rd_addr = id;
    case (state)
      S_RD, S_RD2: mcmd.rd_en = 1'b1;
      S_UNL1: begin
        mcmd.wr_en = (lp != '0); mcmd.wr_sel = ida_pkg::MEM_FWD;
        mcmd.wr_addr = lp; mcmd.wr_data = ln;
      end
      S_UNL2: begin
        mcmd.wr_en = (ln != '0); mcmd.wr_sel = ida_pkg::MEM_BWD;
        mcmd.wr_addr = ln; mcmd.wr_data = lp;
      end
      S_APP1: begin
        mcmd.wr_en = 1'b1; mcmd.wr_sel = ida_pkg::MEM_FREE;
        mcmd.wr_addr = id; mcmd.wr_data = IW'(to_free);
      end
      S_APP2: begin
        mcmd.wr_en = 1'b1; mcmd.wr_sel = ida_pkg::MEM_BWD; mcmd.wr_addr = id;
        mcmd.wr_data = to_free ? '0 : taken_tail;
      end
      S_APP3: begin
        // free push links the old head back; taken append links the old tail on
        mcmd.wr_en = to_free ? (free_head != '0) : (taken_tail != '0);
        mcmd.wr_sel = to_free ? ida_pkg::MEM_BWD : ida_pkg::MEM_FWD;
        mcmd.wr_addr = to_free ? free_head : taken_tail;
        mcmd.wr_data = id;
      end
      S_APP4: begin
        mcmd.wr_en = 1'b1; mcmd.wr_sel = ida_pkg::MEM_FWD; mcmd.wr_addr = id;
        mcmd.wr_data = to_free ? free_head : '0;
      end
      S_FILL1: begin
        mcmd.wr_en = 1'b1; mcmd.wr_sel = ida_pkg::MEM_FREE;
        mcmd.wr_addr = fi; mcmd.wr_data = IW'(1);
      end
      S_FILL2: begin
        mcmd.wr_en = 1'b1; mcmd.wr_sel = ida_pkg::MEM_BWD; mcmd.wr_addr = fi;
        mcmd.wr_data = (fi == first) ? free_tail : fi - IW'(1);
      end
      S_FILL3: begin
        mcmd.wr_en = 1'b1; mcmd.wr_sel = ida_pkg::MEM_FWD; mcmd.wr_addr = fi;
        mcmd.wr_data = (fi == id) ? '0 : fi + IW'(1);
      end
      S_FLNK: begin
        mcmd.wr_en = (free_tail != '0); mcmd.wr_sel = ida_pkg::MEM_FWD;
        mcmd.wr_addr = free_tail; mcmd.wr_data = first;
      end
      default: ;
    endcase
  end

  // list registers and per command bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      high_water <= '0; free_head <= '0; free_tail <= '0;
      taken_head <= '0; taken_tail <= '0; free_total <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          cmd <= req.command; idr <= req.id_in;
          // take reads the links of the free head
          id <= (req.command == ida_pkg::CMD_TAKE) ? free_head : IW'(req.id_in);
          r_id_out <= '0; r_status <= ida_pkg::ST_OK; r_free <= 1'b0;
        end
        S_EVAL: begin
          lp <= mrsp.bwd; ln <= mrsp.fwd;
          case (cmd)
            ida_pkg::CMD_TAKE: begin
              if (free_total != '0 && free_head != '0) begin
                id <= free_head; to_free <= 1'b0;
                r_id_out <= 10'(free_head);
              end else if (high_water < lim) begin
                id <= high_water + IW'(1); to_free <= 1'b0;
                high_water <= high_water + IW'(1);
                r_id_out <= 10'(high_water + IW'(1));
              end else r_status <= ida_pkg::ST_EXH;
            end
            ida_pkg::CMD_FREE: begin
              to_free <= 1'b1;
              if (idr == 10'd0 || !in_mem) r_status <= ida_pkg::ST_RANGE;
              else if (!taken_now) r_status <= ida_pkg::ST_SAME;
            end
            ida_pkg::CMD_RESERVE: begin
              to_free <= 1'b0;
              first <= high_water + IW'(1); fi <= high_water + IW'(1);
              if (idr == 10'd0 || IW'(idr) > lim || !in_mem) r_status <= ida_pkg::ST_RANGE;
              else if (taken_now) r_status <= ida_pkg::ST_SAME;
            end
            ida_pkg::CMD_CHECK: begin
              if (idr == 10'd0 || IW'(idr) > lim || !in_mem) r_status <= ida_pkg::ST_RANGE;
              r_free <= (idr != 10'd0) && in_mem && !taken_now;
            end
            ida_pkg::CMD_NEXT: begin
              if (idr == 10'd0) r_id_out <= 10'(taken_head);
              else if (taken_now) r_id_out <= 10'(mrsp.fwd);
              else r_status <= ida_pkg::ST_RANGE;
            end
            default: ;
          endcase
        end
        S_UNL2: begin
          // head and tail updates of the list being unlinked
          if (cmd == ida_pkg::CMD_FREE) begin
            if (id == taken_head) taken_head <= ln;
            if (id == taken_tail) taken_tail <= lp;
          end else begin
            if (id == free_head) free_head <= ln;
            if (id == free_tail) free_tail <= lp;
            free_total <= free_total - (IW+1)'(1);
          end
        end
        S_APP4: begin
          if (to_free) begin
            if (free_head == '0) free_tail <= id;
            free_head <= id;
            free_total <= free_total + (IW+1)'(1);
          end else begin
            if (taken_tail == '0) taken_head <= id;
            taken_tail <= id;
          end
        end
        S_FILL3: fi <= fi + IW'(1);
        S_FLNK: begin
          if (free_tail == '0) free_head <= first;
          free_tail <= id;
          free_total <= free_total + (IW+1)'(id - high_water);
          high_water <= id;
        end
        S_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      result.id_out <= r_id_out;
      result.status <= r_status;
      result.id_is_free <= r_free;
      result.taken_count <= 10'(high_water - IW'(free_total));
    end
  end

  `IDA_ASSERT_IMP(a_free_bound, clk, ({1'b0, high_water} >= free_total), rst)
  `IDA_ASSERT_NEXT(a_done_once, clk, done, !done, rst)
  `IDA_ASSERT_NEXT(a_done_after, clk, (state == S_DONE), done, rst)
  `IDA_ASSERT_IMP(a_hw_lim, clk, !(state == S_FILL1) || (fi <= id), rst)

endmodule

// ===== sv/id_allocator_free_list_core.sv =====
// top level of the id allocator: sequencer plus link memories
// depends on ida_pkg, ida_ctrl, ida_datapath and the assertion header
//
//  channel  | handshake          | payload
//  request  | start, busy        | req (command, id_in)
//  result   | done (one cycle)   | rsp (id_out, status, id_is_free, taken_count)
//  config   | max_id_we          | max_id_wdata
//
// check, next and rejected commands only read the entry; take appends a fresh
// id above the mark, or unlinks the free head and appends it; free unlinks and
// pushes, each one memory write per cycle on the single write port; reserve
// unlinks and appends, and beyond the mark first fills each new id in.
// reset is synchronous and clears list registers; memories need no clearing.
// the result cannot be stalled; busy drops in the cycle that done pulses.
`include "id_allocator_free_list_core_assert.svh"
module id_allocator_free_list_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ida_pkg::req_t  req,
  input  logic           max_id_we,
  input  logic [9:0]     max_id_wdata,
  output logic           done,
  output ida_pkg::rsp_t  rsp
);

  ida_pkg::mem_cmd_t mcmd;
  ida_pkg::mem_rsp_t mrsp;

  ida_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .max_id_wr(max_id_we), .max_id_data(max_id_wdata),
    .mcmd(mcmd), .mrsp(mrsp), .done(done), .result(rsp)
  );

  ida_datapath u_dp (.clk(clk), .cmd(mcmd), .rsp(mrsp));

  `IDA_ASSERT_IMP(a_done_busy, clk, !done || !busy, rst)
  `IDA_ASSERT_NEXT(a_start_busy, clk, (start && !busy), busy, rst)

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for id_allocator_free_list_core: directed table, then random phases
// depends on ida_pkg and the id_allocator_free_list_core rtl
module tb_top;

  localparam logic [2:0] CMD_BAD_LO = 3'd5;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ida_pkg::req_t req = '0;
  logic max_id_we = 1'b0;
  logic [9:0] max_id_wdata = '0;
  logic done;
  ida_pkg::rsp_t rsp;

  always #5 clk = ~clk;

  id_allocator_free_list_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .max_id_we(max_id_we), .max_id_wdata(max_id_wdata), .done(done), .rsp(rsp)
  );

  // shadow allocator state
  logic [9:0] link_fwd [ida_pkg::MAX_IDS];
  logic [9:0] link_bwd [ida_pkg::MAX_IDS];
  logic       is_free_flag [ida_pkg::MAX_IDS];
  logic [9:0] mark, fhead, ftail, thead, ttail, limit_id;
  logic [10:0] free_cnt;

  ida_pkg::rsp_t pending_rsp [$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cycles = 0;
  logic [9:0] walk_id = '0;

  task automatic report(input string what, input logic [9:0] got, input logic [9:0] want);
    errors++;
    $display("mismatch %0s: got %0d want %0d (result %0d)", what, got, want, results_seen);
  endtask

  function automatic bit taken(input logic [9:0] id);
    return id != 0 && id <= mark && !is_free_flag[id];
  endfunction

  function automatic void unlink_free(input logic [9:0] id);
    logic [9:0] p, n;
    p = link_bwd[id];
    n = link_fwd[id];
    if (p != 0) link_fwd[p] = n;
    if (n != 0) link_bwd[n] = p;
    if (id == fhead) fhead = n;
    if (id == ftail) ftail = p;
    free_cnt--;
  endfunction

  function automatic void unlink_taken(input logic [9:0] id);
    logic [9:0] p, n;
    p = link_bwd[id];
    n = link_fwd[id];
    if (p != 0) link_fwd[p] = n;
    if (n != 0) link_bwd[n] = p;
    if (id == thead) thead = n;
    if (id == ttail) ttail = p;
  endfunction

  function automatic void append_taken(input logic [9:0] id);
    is_free_flag[id] = 1'b0;
    link_bwd[id] = ttail;
    if (ttail != 0) link_fwd[ttail] = id;
    else thead = id;
    ttail = id;
    link_fwd[id] = '0;
  endfunction

  function automatic void push_free(input logic [9:0] id);
    is_free_flag[id] = 1'b1;
    link_bwd[id] = '0;
    link_fwd[id] = fhead;
    if (fhead != 0) link_bwd[fhead] = id;
    else ftail = id;
    fhead = id;
    free_cnt++;
  endfunction

  // expected answer of one command, updating the shadow state
  function automatic ida_pkg::rsp_t predict_alloc(input ida_pkg::req_t r);
    ida_pkg::rsp_t o;
    logic [9:0] id, t, first;
    o = '0;
    o.status = ida_pkg::ST_OK;
    id = r.id_in;
    case (r.command)
      ida_pkg::CMD_TAKE: begin
        if (free_cnt != 0 && fhead != 0) begin
          t = fhead;
          unlink_free(t);
          append_taken(t);
          o.id_out = t;
        end else if (mark < limit_id) begin
          mark++;
          append_taken(mark);
          o.id_out = mark;
        end else begin
          o.status = ida_pkg::ST_EXH;
        end
      end
      ida_pkg::CMD_FREE: begin
        if (id == 0) o.status = ida_pkg::ST_RANGE;
        else if (!taken(id)) o.status = ida_pkg::ST_SAME;
        else begin
          unlink_taken(id);
          push_free(id);
        end
      end
      ida_pkg::CMD_RESERVE: begin
        if (id == 0 || id > limit_id) o.status = ida_pkg::ST_RANGE;
        else if (taken(id)) o.status = ida_pkg::ST_SAME;
        else begin
          if (id > mark) begin
            // fresh ids up to the target join the free tail in ascending order
            first = mark + 1;
            for (int i = first; i <= id; i++) begin
              is_free_flag[i] = 1'b1;
              link_bwd[i] = (i == first) ? ftail : 10'(i - 1);
              link_fwd[i] = (i == id) ? 10'd0 : 10'(i + 1);
            end
            if (ftail != 0) link_fwd[ftail] = first;
            else fhead = first;
            ftail = id;
            free_cnt += 11'(id - mark);
            mark = id;
          end
          unlink_free(id);
          append_taken(id);
        end
      end
      ida_pkg::CMD_CHECK: begin
        if (id == 0 || id > limit_id) o.status = ida_pkg::ST_RANGE;
        if (id != 0) o.id_is_free = !taken(id);
      end
      ida_pkg::CMD_NEXT: begin
        if (id == 0) o.id_out = thead;
        else if (taken(id)) o.id_out = link_fwd[id];
        else o.status = ida_pkg::ST_RANGE;
      end
      default: ;
    endcase
    o.taken_count = 10'(11'(mark) - free_cnt);
    return o;
  endfunction

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected result beat", rsp.id_out, 10'd0);
      end else begin
        ida_pkg::rsp_t want;
        want = pending_rsp.pop_front();
        if (rsp.id_out !== want.id_out) report("id_out", rsp.id_out, want.id_out);
        if (rsp.status !== want.status) report("status", rsp.status, want.status);
        if (rsp.id_is_free !== want.id_is_free)
          report("id_is_free", rsp.id_is_free, want.id_is_free);
        if (rsp.taken_count !== want.taken_count)
          report("taken_count", rsp.taken_count, want.taken_count);
      end
      results_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_rsp.size());
      $display("id_allocator_free_list_core test failed");
      $finish;
    end
  end

  // drive one command beat; start stays high until the caller idles
  task automatic issue(input logic [2:0] cmd, input logic [9:0] id, input bit known,
                       input ida_pkg::rsp_t want);
    ida_pkg::rsp_t pred;
    ida_pkg::req_t r;
    r.command = cmd;
    r.id_in = id;
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = predict_alloc(r);
    if (cmd == ida_pkg::CMD_NEXT) walk_id = pred.id_out;
    pending_rsp.push_back(known ? want : pred);
    items_sent++;
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait for all results, then change the id limit
  task automatic set_limit(input logic [9:0] v);
    pause(1);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    max_id_we <= 1'b1;
    max_id_wdata <= v;
    @(posedge clk);
    max_id_we <= 1'b0;
    limit_id = v;
  endtask

  function automatic logic [9:0] pick_id();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return 10'($urandom_range(mark > 0 ? mark : 1, 1));
    if (sel < 75) return (mark + 10'($urandom_range(6)) > mark) ?
                         mark + 10'($urandom_range(6)) : mark;
    return 10'($urandom_range(1023));
  endfunction

  task automatic run_phase(input int n, input int idle_pct);
    int sel;
    logic [2:0] cmd;
    logic [9:0] id;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      id = pick_id();
      if (sel < 32) cmd = ida_pkg::CMD_TAKE;
      else if (sel < 55) cmd = ida_pkg::CMD_FREE;
      else if (sel < 68) cmd = ida_pkg::CMD_RESERVE;
      else if (sel < 80) cmd = ida_pkg::CMD_CHECK;
      else if (sel < 95) begin
        cmd = ida_pkg::CMD_NEXT;
        if ($urandom_range(3) != 0) id = walk_id;
      end else cmd = 3'($urandom_range(CMD_BAD_HI, CMD_BAD_LO));
      issue(cmd, id, 1'b0, '0);
      if ($urandom_range(99) < idle_pct) pause($urandom_range(6, 1));
    end
  endtask

  typedef struct {
    logic [2:0]    cmd;
    logic [9:0]    id;
    bit            known;
    ida_pkg::rsp_t want;
  } stim_row_t;

  stim_row_t directed [$];

  initial begin
    mark = '0; fhead = '0; ftail = '0; thead = '0; ttail = '0;
    free_cnt = '0;
    limit_id = 10'd1023;
    for (int i = 0; i < ida_pkg::MAX_IDS; i++) begin
      link_fwd[i] = '0;
      link_bwd[i] = '0;
      is_free_flag[i] = 1'b0;
    end

    // directed rows; want is given only where it is obvious
    directed = '{
      '{ida_pkg::CMD_TAKE,    10'd0,    1, '{10'd1, ida_pkg::ST_OK,    1'b0, 10'd1}},
      '{ida_pkg::CMD_TAKE,    10'd0,    1, '{10'd2, ida_pkg::ST_OK,    1'b0, 10'd2}},
      '{ida_pkg::CMD_CHECK,   10'd1,    1, '{10'd0, ida_pkg::ST_OK,    1'b0, 10'd2}},
      '{ida_pkg::CMD_CHECK,   10'd1023, 1, '{10'd0, ida_pkg::ST_OK,    1'b1, 10'd2}},
      '{ida_pkg::CMD_CHECK,   10'd0,    1, '{10'd0, ida_pkg::ST_RANGE, 1'b0, 10'd2}},
      '{ida_pkg::CMD_FREE,    10'd0,    1, '{10'd0, ida_pkg::ST_RANGE, 1'b0, 10'd2}},
      '{ida_pkg::CMD_FREE,    10'd1023, 1, '{10'd0, ida_pkg::ST_SAME,  1'b0, 10'd2}},
      '{ida_pkg::CMD_NEXT,    10'd0,    1, '{10'd1, ida_pkg::ST_OK,    1'b0, 10'd2}},
      '{ida_pkg::CMD_NEXT,    10'd1023, 1, '{10'd0, ida_pkg::ST_RANGE, 1'b0, 10'd2}},
      '{ida_pkg::CMD_FREE,    10'd1,    1, '{10'd0, ida_pkg::ST_OK,    1'b0, 10'd1}},
      '{ida_pkg::CMD_FREE,    10'd1,    1, '{10'd0, ida_pkg::ST_SAME,  1'b0, 10'd1}},
      '{ida_pkg::CMD_NEXT,    10'd1,    1, '{10'd0, ida_pkg::ST_RANGE, 1'b0, 10'd1}},
      '{ida_pkg::CMD_RESERVE, 10'd0,    1, '{10'd0, ida_pkg::ST_RANGE, 1'b0, 10'd1}},
      '{ida_pkg::CMD_RESERVE, 10'd2,    1, '{10'd0, ida_pkg::ST_SAME,  1'b0, 10'd1}},
      '{ida_pkg::CMD_RESERVE, 10'd9,    0, '0},
      '{ida_pkg::CMD_TAKE,    10'd0,    0, '0},
      '{ida_pkg::CMD_NEXT,    10'd0,    0, '0},
      '{ida_pkg::CMD_NEXT,    10'd2,    0, '0},
      '{ida_pkg::CMD_RESERVE, 10'd1,    0, '0},
      '{ida_pkg::CMD_CHECK,   10'd5,    0, '0},
      '{CMD_BAD_LO,           10'd1023, 0, '0},
      '{CMD_BAD_HI,           10'd0,    0, '0},
      '{ida_pkg::CMD_FREE,    10'd9,    0, '0},
      '{ida_pkg::CMD_TAKE,    10'd0,    0, '0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) issue(directed[i].cmd, directed[i].id, directed[i].known,
                                directed[i].want);

    // random phases at several limits and idle rates
    set_limit(10'd1023);
    run_phase(400, 0);
    set_limit(10'd12);
    run_phase(300, 63);
    set_limit(10'd1);
    run_phase(250, 35);
    set_limit(10'd600);
    run_phase(350, 63);
    set_limit(10'd1023);
    run_phase(330, 0);
    // fill the mark all the way to the top id
    issue(ida_pkg::CMD_RESERVE, 10'd1023, 1'b0, '0);
    issue(ida_pkg::CMD_TAKE, 10'd0, 1'b0, '0);
    run_phase(20, 35);
    pause(1);

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d commands sent, %0d results checked, limits 1 to 1023, high mark %0d",
             items_sent, results_seen, mark);
    $display("%0d mismatches", errors);
    if (errors == 0) begin
      $display("id_allocator_free_list_core test passed");
    end else begin
      $display("id_allocator_free_list_core test failed");
    end
    $finish;
  end

endmodule
